// ===== rtl/core/lrap_pkg.sv =====
// shared types and constants of the layered rate adaptation policy
package lrap_pkg;

    localparam int RATE_W   = 20;
    localparam int LEVEL_W  = 16;
    localparam int FILL_W   = 9;
    localparam int WEIGHT_W = 9;
    localparam int SEG_W    = 16;
    localparam int LAYER_W  = 2;
    localparam int FRAC_W   = 8;
    localparam int AVG_W    = RATE_W + FRAC_W;
    localparam int LIMIT_W  = 32;
    localparam int CFG_W    = 20;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(256);
    localparam logic [FILL_W-1:0]   FILL_HIGH  = FILL_W'(192);
    localparam logic [FILL_W-1:0]   FILL_HALF  = FILL_W'(128);

    typedef enum logic [2:0] {
        CFG_EMA_WEIGHT,
        CFG_MIN_BUFFER_LEVEL,
        CFG_GROWING_MARGIN,
        CFG_TOTAL_SEGMENTS,
        CFG_LAYER0_RATE,
        CFG_LAYER1_RATE,
        CFG_LAYER2_RATE,
        CFG_LAYER3_RATE
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_PSTART,
        ST_PICK,
        ST_DECIDE
    } lrap_state_t;

    typedef struct packed {
        logic [RATE_W-1:0]  measured_rate;
        logic [LEVEL_W-1:0] buffer_level;
        logic [FILL_W-1:0]  buffer_fill;
    } req_t;

    typedef struct packed {
        logic [LAYER_W-1:0] layer;
        logic [SEG_W-1:0]   segment_number;
        logic               last_of_segment;
        logic               all_done;
    } rsp_t;

    typedef struct packed {
        cfg_index_t       index;
        logic [CFG_W-1:0] value;
    } cfg_write_t;

    typedef struct packed {
        logic start;
        logic done;
    } lrap_unit_ctl_t;

endpackage

// ===== rtl/core/lrap_stream_if.sv =====
// valid/ready channel carrying one payload per transfer
interface lrap_stream_if #(
    parameter type data_t = logic
) ();

    logic  valid;
    logic  ready;
    data_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

// ===== rtl/core/lrap_ema.sv =====
// bit-serial moving average update, one weight bit per cycle
module lrap_ema (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lrap_pkg::RATE_W-1:0]   rate,
    input  logic [lrap_pkg::AVG_W-1:0]    avg,
    input  logic [lrap_pkg::WEIGHT_W-1:0] weight,
    output logic                          done,
    output logic [lrap_pkg::AVG_W-1:0]    result
);
    import lrap_pkg::*;

    localparam int PA_W  = RATE_W + WEIGHT_W;
    localparam int PB_W  = AVG_W + WEIGHT_W;
    localparam int CNT_W = $clog2(WEIGHT_W);

    logic [WEIGHT_W-1:0] w_sat;
    logic [PA_W-1:0]     mcand_a_reg, mcand_a_next;
    logic [PB_W-1:0]     mcand_b_reg, mcand_b_next;
    logic [WEIGHT_W-1:0] mplier_a_reg, mplier_a_next;
    logic [WEIGHT_W-1:0] mplier_b_reg, mplier_b_next;
    logic [PA_W-1:0]     acc_a_reg, acc_a_next;
    logic [PB_W-1:0]     acc_b_reg, acc_b_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [PA_W-1:0]     sum;

    assign w_sat = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;

    always_comb
    begin
        mcand_a_next  = mcand_a_reg;
        mcand_b_next  = mcand_b_reg;
        mplier_a_next = mplier_a_reg;
        mplier_b_next = mplier_b_reg;
        acc_a_next    = acc_a_reg;
        acc_b_next    = acc_b_reg;
        cnt_next      = cnt_reg;
        busy_next     = busy_reg;
        done_next     = 1'b0;
        if (start)
        begin
            mcand_a_next  = PA_W'(rate);
            mcand_b_next  = PB_W'(avg);
            mplier_a_next = w_sat;
            mplier_b_next = WEIGHT_ONE - w_sat;
            acc_a_next    = '0;
            acc_b_next    = '0;
            cnt_next      = '0;
            busy_next     = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_a_reg[0])
            begin
                acc_a_next = acc_a_reg + mcand_a_reg;
            end
            if (mplier_b_reg[0])
            begin
                acc_b_next = acc_b_reg + mcand_b_reg;
            end
            mcand_a_next  = mcand_a_reg << 1;
            mcand_b_next  = mcand_b_reg << 1;
            mplier_a_next = mplier_a_reg >> 1;
            mplier_b_next = mplier_b_reg >> 1;
            cnt_next      = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(WEIGHT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_a_reg  <= mcand_a_next;
        mcand_b_reg  <= mcand_b_next;
        mplier_a_reg <= mplier_a_next;
        mplier_b_reg <= mplier_b_next;
        acc_a_reg    <= acc_a_next;
        acc_b_reg    <= acc_b_next;
    end

    // rate*w + ((256-w)*avg >> 8)
    assign sum    = acc_a_reg + PA_W'(acc_b_reg[PB_W-1:FRAC_W]);
    assign result = sum[AVG_W-1:0];
    assign done   = done_reg;

endmodule

// ===== rtl/core/lrap_pick.sv =====
// layer scan, one layer bitrate compared per cycle
module lrap_pick #(
    parameter int NUM_LAYERS = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lrap_pkg::lrap_unit_ctl_t       ctl_in,
    output lrap_pkg::lrap_unit_ctl_t       ctl_out,
    input  logic [lrap_pkg::AVG_W-1:0]     avg,
    input  logic [lrap_pkg::FILL_W-1:0]    fill,
    input  logic [lrap_pkg::RATE_W-1:0]    layer_rates [NUM_LAYERS],
    output logic [lrap_pkg::LAYER_W-1:0]   best
);
    import lrap_pkg::*;

    localparam int LIDX_W = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;

    logic [LIMIT_W-1:0] avg_w;
    logic [LIMIT_W-1:0] limit_calc;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic [LIDX_W-1:0]  idx_reg, idx_next;
    logic [LAYER_W-1:0] best_reg, best_next;
    logic [RATE_W-1:0]  best_rate_reg, best_rate_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [RATE_W-1:0]  cur_rate;
    logic [LIMIT_W-1:0] cur_scaled;

    assign avg_w = LIMIT_W'(avg);

    always_comb
    begin
        if (fill > FILL_HIGH)
        begin
            limit_calc = (avg_w << 3) + (avg_w << 2) + avg_w;
        end
        else if (fill > FILL_HALF)
        begin
            limit_calc = (avg_w << 3) + (avg_w << 2);
        end
        else
        begin
            limit_calc = (avg_w << 3) + (avg_w << 1);
        end
    end

    // rate * 2560
    assign cur_rate   = layer_rates[idx_reg];
    assign cur_scaled = (LIMIT_W'(cur_rate) << 11) + (LIMIT_W'(cur_rate) << 9);

    always_comb
    begin
        limit_next     = limit_reg;
        idx_next       = idx_reg;
        best_next      = best_reg;
        best_rate_next = best_rate_reg;
        busy_next      = busy_reg;
        done_next      = 1'b0;
        if (ctl_in.start)
        begin
            limit_next     = limit_calc;
            idx_next       = '0;
            best_next      = '0;
            best_rate_next = '0;
            busy_next      = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cur_scaled < limit_reg && cur_rate > best_rate_reg)
            begin
                best_next      = LAYER_W'(idx_reg);
                best_rate_next = cur_rate;
            end
            idx_next = idx_reg + LIDX_W'(1);
            if (idx_reg == LIDX_W'(NUM_LAYERS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        limit_reg     <= limit_next;
        best_reg      <= best_next;
        best_rate_reg <= best_rate_next;
    end

    assign best          = best_reg;
    assign ctl_out.start = 1'b0;
    assign ctl_out.done  = done_reg;

endmodule

// ===== rtl/core/layered_rate_adaptation_policy.sv =====
// top level of the layered rate adaptation policy
//
//  channel  dir  payload                                            transfer
//  req      in   measured_rate, buffer_level, buffer_fill           valid & ready
//  rsp      out  layer, segment_number, last_of_segment, all_done   valid & ready
//  cfg      in   index, value                                       valid & ready
//
// one request at a time: req is ready only in the idle state, which is entered again once a result is loaded
// a request runs the bit-serial average update, then the one-layer-per-cycle scan, then the decision
// the first request after reset loads the average and skips the serial update
// a result waits in the output register while the next request is taken; the next one stalls
// cfg is always ready; reset is asynchronous, active low
module layered_rate_adaptation_policy #(
    parameter int NUM_LAYERS = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    lrap_stream_if.sink   req,
    lrap_stream_if.source rsp,
    lrap_stream_if.sink   cfg
);
    import lrap_pkg::*;

    lrap_state_t         state_reg, state_next;

    logic [WEIGHT_W-1:0] ema_weight_reg;
    logic [LEVEL_W-1:0]  min_level_reg;
    logic [LEVEL_W-1:0]  margin_reg;
    logic [SEG_W-1:0]    total_reg;
    logic [RATE_W-1:0]   layer_rate_reg [NUM_LAYERS];

    logic [AVG_W-1:0]    avg_reg, avg_next;
    logic                avg_valid_reg, avg_valid_next;
    logic [SEG_W-1:0]    next_segment_reg, next_segment_next;
    logic [LAYER_W-1:0]  next_layer_reg, next_layer_next;
    logic [LAYER_W-1:0]  plan_top_reg, plan_top_next;
    logic                plan_pending_reg, plan_pending_next;
    logic [LEVEL_W-1:0]  level_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic                out_valid_reg, out_valid_next;
    rsp_t                out_data_reg, out_data_next;
    logic                out_load;

    logic                ema_start;
    logic                ema_done;
    logic [AVG_W-1:0]    ema_result;
    lrap_unit_ctl_t      pick_ctl_in;
    lrap_unit_ctl_t      pick_ctl_out;
    logic [LAYER_W-1:0]  pick_best;

    logic                seg_done;
    logic                buffer_low;
    logic [LAYER_W-1:0]  eff_top;
    logic [LAYER_W-1:0]  eff_layer;
    logic                plan_last;

    logic                cfg_fire;
    logic                we_weight, we_min, we_margin, we_total, we_layer;
    logic [LAYER_W-1:0]  layer_sel;

    // configuration decode
    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid & cfg.ready;
    assign layer_sel = LAYER_W'(cfg.data.index - CFG_LAYER0_RATE);

    always_comb
    begin
        we_weight = 1'b0;
        we_min    = 1'b0;
        we_margin = 1'b0;
        we_total  = 1'b0;
        we_layer  = 1'b0;
        unique case (cfg.data.index) inside
            CFG_EMA_WEIGHT:       we_weight = cfg_fire;
            CFG_MIN_BUFFER_LEVEL: we_min    = cfg_fire;
            CFG_GROWING_MARGIN:   we_margin = cfg_fire;
            CFG_TOTAL_SEGMENTS:   we_total  = cfg_fire;
            CFG_LAYER0_RATE, CFG_LAYER1_RATE, CFG_LAYER2_RATE, CFG_LAYER3_RATE:
                                  we_layer  = cfg_fire;
            default:              we_layer  = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ema_weight_reg <= WEIGHT_W'(64);
            min_level_reg  <= LEVEL_W'(2000);
            margin_reg     <= LEVEL_W'(2000);
            total_reg      <= '0;
        end
        else
        begin
            if (we_weight)
            begin
                ema_weight_reg <= cfg.data.value[WEIGHT_W-1:0];
            end
            if (we_min)
            begin
                min_level_reg <= cfg.data.value[LEVEL_W-1:0];
            end
            if (we_margin)
            begin
                margin_reg <= cfg.data.value[LEVEL_W-1:0];
            end
            if (we_total)
            begin
                total_reg <= cfg.data.value[SEG_W-1:0];
            end
        end
    end

    for (genvar i = 0; i < NUM_LAYERS; i++)
    begin : g_layer
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                layer_rate_reg[i] <= '0;
            end
            else if (we_layer && layer_sel == LAYER_W'(i))
            begin
                layer_rate_reg[i] <= cfg.data.value[RATE_W-1:0];
            end
        end
    end

    lrap_ema u_ema (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ema_start),
        .rate   (req.data.measured_rate),
        .avg    (avg_reg),
        .weight (ema_weight_reg),
        .done   (ema_done),
        .result (ema_result)
    );

    lrap_pick #(
        .NUM_LAYERS (NUM_LAYERS)
    ) u_pick (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl_in      (pick_ctl_in),
        .ctl_out     (pick_ctl_out),
        .avg         (avg_reg),
        .fill        (fill_reg),
        .layer_rates (layer_rate_reg),
        .best        (pick_best)
    );

    // plan decision
    assign seg_done   = next_segment_reg >= total_reg;
    assign buffer_low = !(level_reg > min_level_reg) ||
                        (!plan_pending_reg &&
                         ({1'b0, level_reg} < ({1'b0, min_level_reg} + {1'b0, margin_reg})));

    always_comb
    begin
        if (buffer_low)
        begin
            eff_top   = '0;
            eff_layer = '0;
        end
        else if (!plan_pending_reg)
        begin
            eff_top   = pick_best;
            eff_layer = '0;
        end
        else
        begin
            eff_top   = plan_top_reg;
            eff_layer = next_layer_reg;
        end
    end

    assign plan_last = eff_layer >= eff_top;

    always_comb
    begin
        state_next        = state_reg;
        avg_next          = avg_reg;
        avg_valid_next    = avg_valid_reg;
        next_segment_next = next_segment_reg;
        next_layer_next   = next_layer_reg;
        plan_top_next     = plan_top_reg;
        plan_pending_next = plan_pending_reg;
        out_valid_next    = out_valid_reg & ~rsp.ready;
        out_data_next     = out_data_reg;
        out_load          = 1'b0;
        ema_start         = 1'b0;
        pick_ctl_in.start = 1'b0;
        pick_ctl_in.done  = 1'b0;
        req.ready         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    if (avg_valid_reg)
                    begin
                        ema_start  = 1'b1;
                        state_next = ST_AVG;
                    end
                    else
                    begin
                        avg_next       = {req.data.measured_rate, FRAC_W'(0)};
                        avg_valid_next = 1'b1;
                        state_next     = ST_PSTART;
                    end
                end
            end
            ST_AVG:
            begin
                if (ema_done)
                begin
                    avg_next   = ema_result;
                    state_next = ST_PSTART;
                end
            end
            ST_PSTART:
            begin
                pick_ctl_in.start = 1'b1;
                state_next        = ST_PICK;
            end
            ST_PICK:
            begin
                if (pick_ctl_out.done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    out_data_next.segment_number = next_segment_reg;
                    if (seg_done)
                    begin
                        plan_pending_next             = 1'b0;
                        next_layer_next               = '0;
                        out_data_next.layer           = '0;
                        out_data_next.last_of_segment = 1'b0;
                        out_data_next.all_done        = 1'b1;
                    end
                    else
                    begin
                        plan_top_next                 = eff_top;
                        out_data_next.layer           = eff_layer;
                        out_data_next.last_of_segment = plan_last;
                        out_data_next.all_done        = 1'b0;
                        if (plan_last)
                        begin
                            plan_pending_next = 1'b0;
                            next_layer_next   = '0;
                            next_segment_next = next_segment_reg + SEG_W'(1);
                        end
                        else
                        begin
                            plan_pending_next = 1'b1;
                            next_layer_next   = eff_layer + LAYER_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            avg_reg          <= '0;
            avg_valid_reg    <= 1'b0;
            next_segment_reg <= '0;
            next_layer_reg   <= '0;
            plan_top_reg     <= '0;
            plan_pending_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            avg_reg          <= avg_next;
            avg_valid_reg    <= avg_valid_next;
            next_segment_reg <= next_segment_next;
            next_layer_reg   <= next_layer_next;
            plan_top_reg     <= plan_top_next;
            plan_pending_reg <= plan_pending_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (req.valid && req.ready)
        begin
            level_reg <= req.data.buffer_level;
            fill_reg  <= req.data.buffer_fill;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    a_plan_top_range: assert property (@(posedge clk) disable iff (!rst_n)
        plan_top_reg <= LAYER_W'(NUM_LAYERS - 1))
        else $error("plan top beyond last layer");

    a_layer_in_plan: assert property (@(posedge clk) disable iff (!rst_n)
        plan_pending_reg |-> next_layer_reg <= plan_top_reg)
        else $error("next layer past plan top");

    a_segment_step: assert property (@(posedge clk) disable iff (!rst_n)
        (next_segment_reg != $past(next_segment_reg)) |->
            ($past(out_load) && $past(out_data_next.last_of_segment)))
        else $error("segment advanced without a completed plan");

    a_ema_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        ema_done |-> state_reg == ST_AVG)
        else $error("average update finished outside its state");

    a_pick_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        pick_ctl_out.done |-> state_reg == ST_PICK)
        else $error("layer scan finished outside its state");

endmodule
